/* rtl/ffha_pkg.sv */
package ffha_pkg;

    // widths cover the largest heap the block can be built for
    localparam int AW    = 17;
    localparam int CNT_W = 11;
    localparam int FW    = 14;

    localparam int DEF_HEAP_BYTES   = 8192;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_MAX_BLOCKS   = 64;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_GRANT   = 3'd1;
    localparam logic [2:0] OP_SPLIT   = 3'd2;
    localparam logic [2:0] OP_MARK    = 3'd3;
    localparam logic [2:0] OP_MERGE_R = 3'd4;
    localparam logic [2:0] OP_MERGE_L = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic              alloc;
        logic [2:0]        op;
        logic [FW-1:0]     req;
        logic [FW-1:0]     off;
        logic              clr;
        logic [CNT_W-1:0]  cnt;
    } t_cmd;

    typedef struct packed {
        logic          live;
        logic          found;
        logic          fresh;
        logic          pfree;
        logic          nfree;
        logic [AW-1:0] start;
        logic [AW-1:0] size;
    } t_tok;

    typedef struct packed {
        logic [AW-1:0] size;
        logic          free;
        logic          mark;
    } t_ent;

endpackage

/* rtl/ffha_cell.sv */
module ffha_cell import ffha_pkg::*; #(
    parameter int IDX          = 0,
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_tok i_tok,
    input  t_ent i_left,
    input  t_ent i_right,
    output t_tok o_tok,
    output t_ent o_ent
);

    localparam logic [AW-1:0] HDR      = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] RST_SIZE = (IDX == 0) ? AW'(HEAP_BYTES - HEADER_BYTES) : '0;

    logic [AW-1:0] r_size, n_size;
    logic          r_free, n_free;
    logic          r_mark, r_after;
    t_tok          r_tok, n_tok;
    logic          w_valid, w_hit, w_fit;
    logic [AW:0]   w_start_h;

    always_comb begin
        w_valid   = CNT_W'(IDX) < i_cmd.cnt;
        w_start_h = {1'b0, i_tok.start} + {1'b0, HDR};
        w_fit     = i_cmd.alloc ? (r_free && ({1'b0, r_size} >= (AW+1)'(i_cmd.req)))
                                : (w_start_h == (AW+1)'(i_cmd.off));
        w_hit     = i_tok.live && !i_tok.found && w_valid && w_fit;

        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.fresh = 1'b1;
            n_tok.size  = r_size;
            n_tok.nfree = 1'b0;
        end else if (!i_tok.found) begin
            n_tok.start = i_tok.start + HDR + r_size;
            n_tok.pfree = r_free && w_valid;
        end else if (i_tok.fresh) begin
            // first cell behind the hit reports its free state
            n_tok.fresh = 1'b0;
            n_tok.nfree = r_free && w_valid;
        end
    end

    always_comb begin
        n_size = r_size;
        n_free = r_free;
        case (i_cmd.op)
            OP_GRANT: begin
                if (r_mark) n_free = 1'b0;
            end
            OP_MARK: begin
                if (r_mark) n_free = 1'b1;
            end
            OP_SPLIT: begin
                if (r_mark) begin
                    n_size = AW'(i_cmd.req);
                    n_free = 1'b0;
                end else if (i_left.mark) begin
                    n_size = i_left.size - AW'(i_cmd.req) - HDR;
                    n_free = 1'b1;
                end else if (r_after) begin
                    n_size = i_left.size;
                    n_free = i_left.free;
                end
            end
            OP_MERGE_R: begin
                if (r_mark) begin
                    n_size = r_size + HDR + i_right.size;
                end else if (r_after) begin
                    n_size = i_right.size;
                    n_free = i_right.free;
                end
            end
            OP_MERGE_L: begin
                if (i_right.mark) begin
                    n_size = r_size + HDR + i_right.size;
                end else if (r_mark || r_after) begin
                    n_size = i_right.size;
                    n_free = i_right.free;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= RST_SIZE;
            r_free   <= (IDX == 0);
            r_mark   <= 1'b0;
            r_after  <= 1'b0;
            r_tok.live <= 1'b0;
        end else begin
            r_size <= n_size;
            r_free <= n_free;
            r_tok  <= n_tok;
            if (i_cmd.clr) begin
                r_mark  <= 1'b0;
                r_after <= 1'b0;
            end else if (i_tok.live) begin
                r_mark  <= w_hit;
                r_after <= i_tok.found;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_ent = '{size: r_size, free: r_free, mark: r_mark};

endmodule

/* rtl/first_fit_heap_allocator_unit.sv */
// first-fit heap allocator with split and coalesce
// slave channel: one beat per request; tuser is the action (0 allocate, 1 free),
// tdata carries the requested size and the payload offset to free
// master channel: one beat per request with the status in tuser and the granted
// payload offset and size in tdata (both zero unless an allocate succeeds)
// the block table lives in a row of MAX_BLOCKS cells; a search beat walks the
// row one cell per cycle and adds up block offsets on the way; a request steps
// through launch, scan, commit (skipped when the search fails), one merge step
// per free neighbor on a free, and done; a split or merge moves all later
// entries by one cell at once
// one request is in flight at a time; tready is high only while idle, so the
// next request is taken in the cycle after the result is handed to the output
// after reset the table holds one free block spanning the whole heap
// a finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile, and its own result waits in the block
// until the output register is free
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // request_size [13:0], free_offset [27:14], zeros
    input  logic        i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // payload_offset [13:0], granted_size [27:14], zeros
    output logic [1:0]  o_m_tuser    // status
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LAUNCH  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_COMMIT  = 3'd3;
    localparam logic [2:0] S_MERGE_R = 3'd4;
    localparam logic [2:0] S_MERGE_L = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

    logic [2:0]       r_state;
    logic             r_act;
    logic [FW-1:0]    r_req, r_off;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_op;
    logic             r_pf, r_nf;
    logic [1:0]       r_status;
    logic [FW-1:0]    r_pay, r_gsz;
    logic             r_ovalid;
    logic [1:0]       r_ostatus;
    logic [FW-1:0]    r_opay, r_ogsz;

    t_cmd          w_cmd;
    t_tok          w_tok [MAX_BLOCKS+1];
    t_ent          w_ent [MAX_BLOCKS];
    t_tok          w_last;
    logic          w_split;
    logic [AW-1:0] w_pay;
    logic          w_out_free;

    always_comb begin
        w_cmd.alloc = !r_act;
        w_cmd.req   = r_req;
        w_cmd.off   = r_off;
        w_cmd.cnt   = r_cnt;
        w_cmd.clr   = (r_state == S_DONE);
        case (r_state)
            S_COMMIT:  w_cmd.op = r_op;
            S_MERGE_R: w_cmd.op = OP_MERGE_R;
            S_MERGE_L: w_cmd.op = OP_MERGE_L;
            default:   w_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        w_tok[0]      = '0;
        w_tok[0].live = (r_state == S_LAUNCH);
    end

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        t_ent w_l, w_r;
        if (g == 0) begin : g_first
            assign w_l = '0;
        end else begin : g_mid_l
            assign w_l = w_ent[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_last
            assign w_r = '0;
        end else begin : g_mid_r
            assign w_r = w_ent[g+1];
        end
        ffha_cell #(
            .IDX          (g),
            .HEAP_BYTES   (HEAP_BYTES),
            .HEADER_BYTES (HEADER_BYTES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .i_left  (w_l),
            .i_right (w_r),
            .o_tok   (w_tok[g+1]),
            .o_ent   (w_ent[g])
        );
    end

    assign w_last     = w_tok[MAX_BLOCKS];
    assign w_split    = ({1'b0, w_last.size} > ((AW+1)'(r_req) + (AW+1)'(HEADER_BYTES)))
                        && (r_cnt < CNT_W'(MAX_BLOCKS));
    assign w_pay      = w_last.start + HDR;
    assign w_out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= CNT_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) r_ovalid <= 1'b1;
            else if (i_m_tready)                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act   <= i_s_tuser;
                        r_req   <= i_s_tdata[FW-1:0];
                        r_off   <= i_s_tdata[2*FW-1:FW];
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: r_state <= S_SCAN;
                S_SCAN: begin
                    if (w_last.live) begin
                        r_pf <= w_last.pfree;
                        r_nf <= w_last.nfree;
                        if (!w_last.found) begin
                            r_status <= r_act ? ST_BADFREE : ST_OOM;
                            r_pay    <= '0;
                            r_gsz    <= '0;
                            r_state  <= S_DONE;
                        end else if (!r_act) begin
                            r_status <= ST_OK;
                            r_pay    <= w_pay[FW-1:0];
                            r_gsz    <= w_split ? r_req : w_last.size[FW-1:0];
                            r_op     <= w_split ? OP_SPLIT : OP_GRANT;
                            r_state  <= S_COMMIT;
                        end else begin
                            r_status <= ST_OK;
                            r_pay    <= '0;
                            r_gsz    <= '0;
                            r_op     <= OP_MARK;
                            r_state  <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT: begin
                    if (r_op == OP_SPLIT) r_cnt <= r_cnt + CNT_W'(1);
                    if (!r_act)    r_state <= S_DONE;
                    else if (r_nf) r_state <= S_MERGE_R;
                    else if (r_pf) r_state <= S_MERGE_L;
                    else           r_state <= S_DONE;
                end
                S_MERGE_R: begin
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_state <= r_pf ? S_MERGE_L : S_DONE;
                end
                S_MERGE_L: begin
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ostatus <= r_status;
                        r_opay    <= r_pay;
                        r_ogsz    <= r_gsz;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = {4'b0, r_ogsz, r_opay};

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_last.live) |=> (r_state != S_SCAN))
        else $error("search beat left the row but scan continued");

    a_launch_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAUNCH) |=> !w_tok[0].live && w_tok[1].live)
        else $error("search beat not launched into the first cell");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata == 32'd0))
        else $error("failed request carries nonzero data");

endmodule
